// File: hw/rtl/khd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the KISS host deframer.
// Used by khd_parser and kiss_host_deframer_unit; depends on nothing.

package khd_pkg;

    localparam int MaxFrame = 512;
    localparam int CountW   = 10;
    localparam int SetW     = 12;

    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    localparam logic [4:0] OP_DATA     = 5'h00;
    localparam logic [4:0] OP_TXDELAY  = 5'h01;
    localparam logic [4:0] OP_P        = 5'h02;
    localparam logic [4:0] OP_SLOTTIME = 5'h03;
    localparam logic [4:0] OP_TXTAIL   = 5'h04;
    localparam logic [4:0] OP_READY    = 5'h0F;
    localparam logic [4:0] OP_NONE     = 5'h10;

    localparam logic [CountW-1:0] MAX_COUNT = CountW'(MaxFrame);
    localparam logic [CountW-1:0] COUNT_ONE = CountW'(1);

    localparam logic [SetW-1:0] DELAY_RESET   = 12'd350;
    localparam logic [SetW-1:0] TAIL_RESET    = 12'd50;
    localparam logic [SetW-1:0] SLOT_RESET    = 12'd200;
    localparam logic [7:0]      PERSIST_RESET = 8'd63;

    localparam int TDATA_W = 64;

    typedef struct packed {
        logic              data_valid;
        logic [7:0]        data_byte;
        logic              frame_done;
        logic [CountW-1:0] frame_length;
        logic [SetW-1:0]   tx_delay_ms;
        logic [SetW-1:0]   tx_tail_ms;
        logic [SetW-1:0]   slot_time_ms;
        logic [7:0]        persistence;
        logic              flow_control;
    } khd_result_t;

    function automatic logic [SetW-1:0] times_ten(input logic [7:0] b);
        logic [SetW-1:0] w;
        begin
            w = SetW'(b);
            return (w << 3) + (w << 1);
        end
    endfunction

endpackage

// File: hw/rtl/khd_parser.sv
`timescale 1ns / 1ps
// Frame parser state and per-byte decision logic of the KISS host deframer.
// Depends on khd_pkg for framing codes, command codes and the result type.

module khd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output khd_pkg::khd_result_t result
);

    logic                      frame_open_reg, frame_open_next;
    logic                      escape_reg, escape_next;
    logic [4:0]                cmd_reg, cmd_next;
    logic [khd_pkg::CountW-1:0] count_reg, count_next;
    logic [khd_pkg::SetW-1:0]  delay_reg, delay_next;
    logic [khd_pkg::SetW-1:0]  tail_reg, tail_next;
    logic [khd_pkg::SetW-1:0]  slot_reg, slot_next;
    logic [7:0]                persist_reg, persist_next;
    logic                      flow_reg, flow_next;
    logic                      valid;
    logic [7:0]                dbyte;
    logic                      done;
    logic [khd_pkg::SetW-1:0]  scaled;

    assign scaled = khd_pkg::times_ten(rx_byte);

    always_comb
    begin
        frame_open_next = frame_open_reg;
        escape_next     = escape_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        delay_next      = delay_reg;
        tail_next       = tail_reg;
        slot_next       = slot_reg;
        persist_next    = persist_reg;
        flow_next       = flow_reg;
        valid           = 1'b0;
        dbyte           = 8'd0;
        done            = 1'b0;
        if (frame_open_reg && rx_byte == khd_pkg::FEND && cmd_reg == khd_pkg::OP_DATA)
        begin
            frame_open_next = 1'b0;
            done            = 1'b1;
        end
        else if (rx_byte == khd_pkg::FEND)
        begin
            frame_open_next = 1'b1;
            cmd_next        = khd_pkg::OP_NONE;
            count_next      = '0;
        end
        else if (frame_open_reg && count_reg < khd_pkg::MAX_COUNT)
        begin
            if (count_reg == '0 && cmd_reg == khd_pkg::OP_NONE)
            begin
                cmd_next = {1'b0, rx_byte[3:0]};
            end
            else
            begin
                case (cmd_reg)
                    khd_pkg::OP_DATA:
                    begin
                        if (rx_byte == khd_pkg::FESC)
                        begin
                            escape_next = 1'b1;
                        end
                        else
                        begin
                            dbyte = rx_byte;
                            if (escape_reg)
                            begin
                                if (rx_byte == khd_pkg::TFEND)
                                begin
                                    dbyte = khd_pkg::FEND;
                                end
                                else if (rx_byte == khd_pkg::TFESC)
                                begin
                                    dbyte = khd_pkg::FESC;
                                end
                                escape_next = 1'b0;
                            end
                            valid      = 1'b1;
                            count_next = count_reg + khd_pkg::COUNT_ONE;
                        end
                    end
                    khd_pkg::OP_TXDELAY:  delay_next   = scaled;
                    khd_pkg::OP_TXTAIL:   tail_next    = scaled;
                    khd_pkg::OP_SLOTTIME: slot_next    = scaled;
                    khd_pkg::OP_P:        persist_next = rx_byte;
                    khd_pkg::OP_READY:    flow_next    = (rx_byte != 8'd0);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            escape_reg     <= 1'b0;
            cmd_reg        <= khd_pkg::OP_NONE;
            count_reg      <= '0;
            delay_reg      <= khd_pkg::DELAY_RESET;
            tail_reg       <= khd_pkg::TAIL_RESET;
            slot_reg       <= khd_pkg::SLOT_RESET;
            persist_reg    <= khd_pkg::PERSIST_RESET;
            flow_reg       <= 1'b0;
        end
        else if (step)
        begin
            frame_open_reg <= frame_open_next;
            escape_reg     <= escape_next;
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            delay_reg      <= delay_next;
            tail_reg       <= tail_next;
            slot_reg       <= slot_next;
            persist_reg    <= persist_next;
            flow_reg       <= flow_next;
        end
    end

    always_comb
    begin
        result.data_valid   = valid;
        result.data_byte    = dbyte;
        result.frame_done   = done;
        result.frame_length = count_next;
        result.tx_delay_ms  = delay_next;
        result.tx_tail_ms   = tail_next;
        result.slot_time_ms = slot_next;
        result.persistence  = persist_next;
        result.flow_control = flow_next;
    end

endmodule

// File: hw/rtl/kiss_host_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the KISS host deframer: input register, parser, result register.
// Depends on khd_pkg and khd_parser.
//
// The slave stream takes one host serial byte per request in s_axis_tdata.
// For every byte the master stream gives exactly one result: tuser flags an
// unescaped payload byte, tlast flags the FEND that closes a data frame, and
// tdata carries the payload byte, the running frame length and the current
// TXDELAY, TXTAIL, SLOTTIME, persistence and flow control settings.
// A byte is held in an input register, parsed by one short combinational
// step that also updates the frame state, and the result is registered.
// The result is offered once its byte has moved from the input register into
// the result register, and a new byte is taken every cycle while the master
// side keeps taking results.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte; after that s_axis_tready drops
// until the result is taken. Reset empties both registers, leaves the block
// outside any frame, and restores the default settings (350, 50, 200, 63,
// flow control off).

module kiss_host_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [khd_pkg::TDATA_W-1:0] m_axis_tdata,
    // [7:0] data_byte, [17:8] frame_length, [29:18] tx_delay_ms,
    // [41:30] tx_tail_ms, [53:42] slot_time_ms, [61:54] persistence,
    // [62] flow_control, [63] zero
    output logic        m_axis_tuser,   // [0] data_valid
    output logic        m_axis_tlast    // frame_done
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    khd_pkg::khd_result_t out_reg;
    khd_pkg::khd_result_t result;
    logic                 advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    khd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.data_valid;
    assign m_axis_tlast  = out_reg.frame_done;
    assign m_axis_tdata  = {1'b0, out_reg.flow_control, out_reg.persistence,
                            out_reg.slot_time_ms, out_reg.tx_tail_ms,
                            out_reg.tx_delay_ms, out_reg.frame_length,
                            out_reg.data_byte};

endmodule

// File: bench/tb_kiss_host_deframer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for kiss_host_deframer_unit: directed KISS cases, then random frames.
// It predicts each byte's result in a local parser and checks every result field. Needs khd_pkg.

module tb_kiss_host_deframer_unit;

    localparam int IdleLimit = 2000;
    localparam int FullFrameBytes = khd_pkg::MaxFrame + 18;
    localparam int ScaleMs = 10;
    localparam int UnusedCmdLo = 5;
    localparam int UnusedCmdHi = 14;

    typedef struct packed {
        bit                       data_valid;
        bit [7:0]                 data_byte;
        bit                       frame_done;
        bit [khd_pkg::CountW-1:0] frame_length;
        bit [khd_pkg::SetW-1:0]   tx_delay_ms;
        bit [khd_pkg::SetW-1:0]   tx_tail_ms;
        bit [khd_pkg::SetW-1:0]   slot_time_ms;
        bit [7:0]                 persistence;
        bit                       flow_control;
    } host_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [khd_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         m_axis_tlast;

    bit                           frame_open = 1'b0;
    bit                           escape_pending = 1'b0;
    bit [4:0]                     frame_cmd = khd_pkg::OP_NONE;
    bit [khd_pkg::CountW-1:0]     stored_count = '0;
    bit [khd_pkg::SetW-1:0]       delay_ms = khd_pkg::DELAY_RESET;
    bit [khd_pkg::SetW-1:0]       tail_ms = khd_pkg::TAIL_RESET;
    bit [khd_pkg::SetW-1:0]       slot_ms = khd_pkg::SLOT_RESET;
    bit [7:0]                     persist = khd_pkg::PERSIST_RESET;
    bit                           flow_on = 1'b0;

    bit [7:0]                     host_bytes[$];
    host_result_t                 predicted_results[$];
    host_result_t                 oldest;
    int                           idle_pct = 18;
    int                           bytes_queued = 0;
    int                           bytes_taken = 0;
    int                           results_seen = 0;
    int                           payload_seen = 0;
    int                           frames_closed = 0;
    int                           mismatches = 0;
    int                           quiet_cycles = 0;

    bit [7:0] directed[$] = '{
        8'h55, khd_pkg::FEND, 8'h10, 8'h00, 8'hFF, khd_pkg::FESC, khd_pkg::TFEND,
        khd_pkg::FESC, khd_pkg::TFESC, khd_pkg::FESC, 8'h7E, khd_pkg::FESC, khd_pkg::FEND,
        khd_pkg::FEND, 8'h00, khd_pkg::TFEND, khd_pkg::FEND,
        khd_pkg::FEND, 8'h01, 8'hFF, khd_pkg::FEND, 8'h02, 8'h00, khd_pkg::FEND,
        8'h03, 8'hFF, khd_pkg::FEND, 8'h04, 8'h80,
        khd_pkg::FEND, 8'h0F, 8'h07, 8'h00, khd_pkg::FEND, 8'h09, 8'h44, khd_pkg::FEND
    };

    kiss_host_deframer_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void parse_host_byte(input bit [7:0] rx);
        host_result_t r;
        bit [7:0]     b;
        b = rx;
        r = '0;
        if (frame_open && b == khd_pkg::FEND && frame_cmd == khd_pkg::OP_DATA)
        begin
            frame_open = 1'b0;
            r.frame_done = 1'b1;
        end
        else if (b == khd_pkg::FEND)
        begin
            frame_open = 1'b1;
            frame_cmd = khd_pkg::OP_NONE;
            stored_count = '0;
        end
        else if (frame_open && stored_count < khd_pkg::MAX_COUNT)
        begin
            if (stored_count == '0 && frame_cmd == khd_pkg::OP_NONE)
                frame_cmd = {1'b0, b[3:0]};
            else
            begin
                case (frame_cmd)
                    khd_pkg::OP_DATA:
                    begin
                        if (b == khd_pkg::FESC)
                            escape_pending = 1'b1;
                        else
                        begin
                            if (escape_pending)
                            begin
                                if (b == khd_pkg::TFEND)
                                    b = khd_pkg::FEND;
                                else if (b == khd_pkg::TFESC)
                                    b = khd_pkg::FESC;
                                escape_pending = 1'b0;
                            end
                            r.data_valid = 1'b1;
                            r.data_byte = b;
                            stored_count = stored_count + khd_pkg::COUNT_ONE;
                        end
                    end
                    khd_pkg::OP_TXDELAY:
                        delay_ms = khd_pkg::SetW'(b) * khd_pkg::SetW'(ScaleMs);
                    khd_pkg::OP_TXTAIL:
                        tail_ms = khd_pkg::SetW'(b) * khd_pkg::SetW'(ScaleMs);
                    khd_pkg::OP_SLOTTIME:
                        slot_ms = khd_pkg::SetW'(b) * khd_pkg::SetW'(ScaleMs);
                    khd_pkg::OP_P:        persist = b;
                    khd_pkg::OP_READY:    flow_on = (b != 8'h00);
                    default:      ;
                endcase
            end
        end
        r.frame_length = stored_count;
        r.tx_delay_ms = delay_ms;
        r.tx_tail_ms = tail_ms;
        r.slot_time_ms = slot_ms;
        r.persistence = persist;
        r.flow_control = flow_on;
        predicted_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_host_byte(s_axis_tdata);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (host_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    s_axis_tdata <= host_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    oldest = predicted_results.pop_front();
                    check_field("data_valid", 32'(oldest.data_valid), 32'(m_axis_tuser));
                    check_field("data_byte", 32'(oldest.data_byte), 32'(m_axis_tdata[7:0]));
                    check_field("frame_done", 32'(oldest.frame_done), 32'(m_axis_tlast));
                    check_field("frame_length", 32'(oldest.frame_length),
                                32'(m_axis_tdata[17:8]));
                    check_field("tx_delay_ms", 32'(oldest.tx_delay_ms),
                                32'(m_axis_tdata[29:18]));
                    check_field("tx_tail_ms", 32'(oldest.tx_tail_ms),
                                32'(m_axis_tdata[41:30]));
                    check_field("slot_time_ms", 32'(oldest.slot_time_ms),
                                32'(m_axis_tdata[53:42]));
                    check_field("persistence", 32'(oldest.persistence),
                                32'(m_axis_tdata[61:54]));
                    check_field("flow_control", 32'(oldest.flow_control),
                                32'(m_axis_tdata[62]));
                    if (oldest.data_valid)
                        payload_seen++;
                    if (oldest.frame_done)
                        frames_closed++;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IdleLimit)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_byte(input bit [7:0] b);
        host_bytes.push_back(b);
        bytes_queued++;
    endtask

    function automatic bit [7:0] non_fend_byte();
        bit [7:0] b;
        b = 8'($urandom);
        if (b == khd_pkg::FEND)
            b = ~b;
        return b;
    endfunction

    task automatic queue_data_payload(input int len);
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                queue_byte(khd_pkg::FESC);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    queue_byte(khd_pkg::TFEND);
                else if (pick < 90)
                    queue_byte(khd_pkg::TFESC);
                else
                    queue_byte(non_fend_byte());
            end
            else if (pick < 11)
                queue_byte(8'h00);
            else if (pick < 14)
                queue_byte(8'hFF);
            else
                queue_byte(non_fend_byte());
        end
    endtask

    task automatic queue_random_frame();
        bit [3:0] low;
        bit [7:0] cmd_byte;
        int       pick;
        if ($urandom_range(0, 99) < 55)
            low = khd_pkg::OP_DATA[3:0];
        else
        begin
            case ($urandom_range(0, 6))
                0:       low = khd_pkg::OP_TXDELAY[3:0];
                1:       low = khd_pkg::OP_P[3:0];
                2:       low = khd_pkg::OP_SLOTTIME[3:0];
                3:       low = khd_pkg::OP_TXTAIL[3:0];
                4:       low = 4'($urandom_range(UnusedCmdLo, UnusedCmdHi));
                default: low = khd_pkg::OP_READY[3:0];
            endcase
        end
        cmd_byte = {4'($urandom_range(0, 15)), low};
        if (cmd_byte == khd_pkg::FEND)
            cmd_byte[7:4] = 4'h0;
        queue_byte(khd_pkg::FEND);
        queue_byte(cmd_byte);
        if (low == khd_pkg::OP_DATA[3:0])
        begin
            queue_data_payload($urandom_range(0, 24));
            if ($urandom_range(0, 99) < 5)
                queue_byte(khd_pkg::FESC);
        end
        else
        begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    queue_byte(8'h00);
                else if (pick < 30)
                    queue_byte(8'hFF);
                else
                    queue_byte(non_fend_byte());
            end
        end
        queue_byte(khd_pkg::FEND);
    endtask

    task automatic queue_noise();
        int pick;
        for (int i = $urandom_range(1, 5); i > 0; i--)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                queue_byte(khd_pkg::FEND);
            else if (pick < 40)
                queue_byte(khd_pkg::FESC);
            else if (pick < 50)
                queue_byte(khd_pkg::TFEND);
            else if (pick < 60)
                queue_byte(khd_pkg::TFESC);
            else
                queue_byte(8'($urandom));
        end
    endtask

    task automatic queue_random_until(input int target);
        while (bytes_queued < target)
        begin
            if ($urandom_range(0, 99) < 85)
                queue_random_frame();
            else
                queue_noise();
        end
    endtask

    task automatic wait_drained();
        while (host_bytes.size() != 0 || bytes_taken != bytes_queued
               || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_sent();
        while (host_bytes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            queue_byte(directed[i]);
        wait_drained();

        queue_random_until(500);
        wait_sent();

        idle_pct = 0;
        queue_byte(khd_pkg::FEND);
        queue_byte({3'b000, khd_pkg::OP_DATA});
        queue_data_payload(FullFrameBytes);
        queue_byte(khd_pkg::FESC);
        queue_byte(khd_pkg::FEND);
        queue_random_until(bytes_queued + 300);
        wait_sent();

        idle_pct = 18;
        queue_random_until(1450);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d host bytes and checked %0d results: %0d payload bytes, %0d frames.",
                 bytes_queued, results_seen, payload_seen, frames_closed);
        $display("Included directed escape and settings cases and one frame past %0d bytes.",
                 khd_pkg::MaxFrame);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
